// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/core/dewq_pkg.sv =====
package dewq_pkg;

    localparam int DEWQ_DEPTH     = 16;
    localparam int DEWQ_WORK_BITS = 32;

    localparam int CMD_BITS    = 2;
    localparam int WORD_BITS   = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 5;

    localparam logic [CMD_BITS-1:0] CMD_PUSH_TOP    = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_PUSH_BOTTOM = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_POP_TOP     = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_POP_BOTTOM  = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_BITS-1:0]  cmd;
        logic [WORD_BITS-1:0] work_in;
    } t_cmd_item;

    typedef struct packed {
        logic [WORD_BITS-1:0]   work_out;
        logic [STATUS_BITS-1:0] status;
        logic [COUNT_BITS-1:0]  count;
    } t_result;

    typedef struct packed {
        logic exec;
        logic capture;
    } t_dp_ctrl;

    typedef struct packed {
        logic pop_hit;
    } t_dp_status;

endpackage

// ===== rtl/core/dewq_ram.sv =====
module dewq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/dewq_ctrl.sv =====
`include "assert_macros.svh"

module dewq_ctrl
    import dewq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_dp_status i_status,
    output t_dp_ctrl   o_ctrl,
    output logic       busy,
    output logic       o_valid
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_READ = 1'b1;

    logic [0:0] r_state;
    logic [0:0] n_state;
    logic       r_valid;
    logic       n_valid;

    always_comb begin
        o_ctrl.exec    = 1'b0;
        o_ctrl.capture = 1'b0;
        n_state        = r_state;
        n_valid        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.exec = start;
                if (start) begin
                    if (i_status.pop_hit) begin
                        n_state = S_READ;
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_ctrl.capture = 1'b1;
                n_valid        = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

    `ASSERT_NEVER(a_no_beat_while_busy, i_clk, i_rst_n, busy && o_valid)
    `ASSERT_PROP(a_pop_beat_follows, i_clk, i_rst_n, (start && !busy && i_status.pop_hit) |=> busy ##1 o_valid)

endmodule

// ===== rtl/core/dewq_datapath.sv =====
`include "assert_macros.svh"

module dewq_datapath
    import dewq_pkg::*;
#(
    parameter int DEPTH     = DEWQ_DEPTH,
    parameter int WORK_BITS = DEWQ_WORK_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd_item  i_item,
    input  t_dp_ctrl   i_ctrl,
    output t_dp_status o_status,
    output t_result    o_result
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [IDX_W-1:0]     r_top;
    logic [IDX_W-1:0]     n_top;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    t_result              r_res;
    logic [STATUS_BITS-1:0] n_status;

    logic                 full;
    logic                 empty;
    logic [IDX_W-1:0]     top_dec;
    logic [IDX_W-1:0]     top_inc;
    logic [SUM_W-1:0]     slot_sum;
    logic [SUM_W-1:0]     slot_wrap;
    logic [IDX_W-1:0]     slot;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [WORK_BITS-1:0] rd_data;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    assign top_dec = (r_top == '0) ? IDX_W'(DEPTH - 1) : r_top - 1'b1;
    assign top_inc = (r_top == IDX_W'(DEPTH - 1)) ? '0 : r_top + 1'b1;

    assign slot_sum  = SUM_W'(r_top) + SUM_W'(r_count)
                     - SUM_W'(i_item.cmd == CMD_POP_BOTTOM);
    assign slot_wrap = (slot_sum >= SUM_W'(DEPTH)) ? slot_sum - SUM_W'(DEPTH) : slot_sum;
    assign slot      = slot_wrap[IDX_W-1:0];

    assign o_status.pop_hit = ((i_item.cmd == CMD_POP_TOP) || (i_item.cmd == CMD_POP_BOTTOM))
                              && !empty;

    always_comb begin
        n_top    = r_top;
        n_count  = r_count;
        n_status = ST_DONE;
        wr_en    = 1'b0;
        wr_addr  = slot;
        rd_en    = 1'b0;
        rd_addr  = slot;
        unique case (i_item.cmd)
            CMD_PUSH_TOP: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_top   = top_dec;
                    wr_en   = 1'b1;
                    wr_addr = top_dec;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_PUSH_BOTTOM: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_TOP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_top;
                    n_top   = top_inc;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_POP_BOTTOM: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
        // drop the top index back to zero once the queue drains
        if (!wr_en && (n_count == '0)) begin
            n_top = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_count <= '0;
        end else if (i_ctrl.exec) begin
            r_top   <= n_top;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            r_res.work_out <= '0;
            r_res.status   <= n_status;
            r_res.count    <= COUNT_BITS'(n_count);
        end else if (i_ctrl.capture) begin
            r_res.work_out <= WORD_BITS'(rd_data);
        end
    end

    dewq_ram #(
        .WIDTH (WORK_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en && i_ctrl.exec),
        .i_wr_addr (wr_addr),
        .i_wr_data (WORK_BITS'(i_item.work_in)),
        .i_rd_en   (rd_en && i_ctrl.exec),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_result = r_res;

    `ASSERT_NEVER(a_count_in_range, i_clk, i_rst_n, r_count > CNT_W'(DEPTH))
    `ASSERT_PROP(a_drained_top_zero, i_clk, i_rst_n, (r_count == '0) |-> (r_top == '0))

endmodule

// ===== rtl/core/double_ended_work_queue.sv =====
// Channel   Direction  Handshake                 Beat
// command   in         start high, busy low      i_item  (cmd, work_in)
// result    out        o_valid for one cycle     o_result (work_out, status, count)
//
// Push, and pop on an empty queue: the result beat shows in the cycle after the command.
// Pop from a non-empty queue: busy high for one cycle, set by the registered
// read port of the entry store; the result beat shows in the cycle in which busy falls.
// Synchronous active-low reset empties the queue at once; entry contents stay undefined.
// The receiver cannot stall: every result beat is shown for exactly one cycle.
module double_ended_work_queue
    import dewq_pkg::*;
#(
    parameter int DEPTH     = DEWQ_DEPTH,
    parameter int WORK_BITS = DEWQ_WORK_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_cmd_item i_item,
    output logic      o_valid,
    output t_result   o_result
);

    t_dp_ctrl   w_ctrl;
    t_dp_status w_status;

    dewq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_ctrl   (w_ctrl),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    dewq_datapath #(
        .DEPTH     (DEPTH),
        .WORK_BITS (WORK_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctrl   (w_ctrl),
        .o_status (w_status),
        .o_result (o_result)
    );

endmodule

// ===== tb/deque_result_checker.sv =====
`timescale 1ns / 1ps

module deque_result_checker
    import dewq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_cmd_item i_item,
    input  logic      i_valid,
    input  t_result   i_result,
    output int        o_fail_count,
    output int        o_outstanding
);

    localparam int IDX_BITS = $clog2(DEWQ_DEPTH);

    logic [WORD_BITS-1:0]  held_words [DEWQ_DEPTH];
    logic [IDX_BITS-1:0]   top_slot;
    logic [COUNT_BITS-1:0] held_count;
    t_result               expected_results [$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        top_slot      = '0;
        held_count    = '0;
    end

    function automatic t_result next_deque_result(input t_cmd_item item);
        t_result             res;
        logic [IDX_BITS-1:0] slot;
        res        = '0;
        res.status = ST_DONE;
        case (item.cmd)
            CMD_PUSH_TOP, CMD_PUSH_BOTTOM: begin
                if (held_count == COUNT_BITS'(DEWQ_DEPTH)) begin
                    res.status = ST_FULL;
                end else if (item.cmd == CMD_PUSH_TOP) begin
                    top_slot             = top_slot - 1'b1;
                    held_words[top_slot] = item.work_in;
                    held_count           = held_count + 1'b1;
                end else begin
                    slot             = top_slot + held_count[IDX_BITS-1:0];
                    held_words[slot] = item.work_in;
                    held_count       = held_count + 1'b1;
                end
            end
            default: begin
                if (held_count == '0) begin
                    res.status = ST_EMPTY;
                end else if (item.cmd == CMD_POP_TOP) begin
                    res.work_out = held_words[top_slot];
                    top_slot     = top_slot + 1'b1;
                    held_count   = held_count - 1'b1;
                end else begin
                    slot         = top_slot + held_count[IDX_BITS-1:0] - 1'b1;
                    res.work_out = held_words[slot];
                    held_count   = held_count - 1'b1;
                end
                if (held_count == '0) begin
                    top_slot = '0;
                end
            end
        endcase
        res.count = held_count;
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [WORD_BITS-1:0] want,
                                 input logic [WORD_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            expected_results.delete();
            top_slot   = '0;
            held_count = '0;
        end else begin
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat: expected none, actual %0h",
                             $time, i_result);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("work_out", want.work_out, i_result.work_out);
                    compare_field("status", WORD_BITS'(want.status), WORD_BITS'(i_result.status));
                    compare_field("count", WORD_BITS'(want.count), WORD_BITS'(i_result.count));
                end
            end
            if (i_start && !i_busy) begin
                expected_results.push_back(next_deque_result(i_item));
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import dewq_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int IDLE_LIMIT   = 1000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_cmd_item i_item;
    logic      o_valid;
    t_result   o_result;
    int        fail_count;
    int        outstanding;
    int        idle_cycles;

    double_ended_work_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    deque_result_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (i_item),
        .i_valid       (o_valid),
        .i_result      (o_result),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic issue_beat(input logic [CMD_BITS-1:0] op, input logic [WORD_BITS-1:0] word);
        t_cmd_item item;
        item.cmd     = op;
        item.work_in = word;
        i_item <= item;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return WORD_BITS'($urandom);
        endcase
    endfunction

    initial begin
        int                   burst_left;
        int                   phase_left;
        int                   push_pct;
        int                   gap;
        logic [CMD_BITS-1:0]  op;
        start   <= 1'b0;
        i_item  <= '0;
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue_beat(CMD_POP_TOP, '1);
        issue_beat(CMD_POP_BOTTOM, '0);
        issue_beat(CMD_PUSH_TOP, '1);
        issue_beat(CMD_PUSH_BOTTOM, '0);
        issue_beat(CMD_POP_BOTTOM, '1);
        issue_beat(CMD_POP_TOP, '0);
        for (int k = 0; k < DEWQ_DEPTH; k++) begin
            issue_beat(k[0] ? CMD_PUSH_BOTTOM : CMD_PUSH_TOP, pick_word());
        end
        issue_beat(CMD_PUSH_TOP, '1);
        issue_beat(CMD_PUSH_BOTTOM, '1);
        issue_beat(CMD_POP_TOP, '0);
        issue_beat(CMD_POP_BOTTOM, '0);

        burst_left = $urandom_range(1, 16);
        phase_left = 0;
        push_pct   = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
                phase_left = $urandom_range(20, 80);
            end
            phase_left = phase_left - 1;
            if ($urandom_range(0, 99) < push_pct) begin
                op = $urandom_range(0, 1) ? CMD_PUSH_BOTTOM : CMD_PUSH_TOP;
            end else begin
                op = $urandom_range(0, 1) ? CMD_POP_BOTTOM : CMD_POP_TOP;
            end
            issue_beat(op, pick_word());
            burst_left = burst_left - 1;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 16);
            end
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
